### sv/ple_pkg.sv
// ple_pkg: shared types and codes for the positional list engine
// holds request and status codes and the cell control struct
// no dependencies
package ple_pkg;

  localparam int POS_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int LEN_OUT_W  = 5;

  // request codes
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;   // committed insert this cycle
    logic             rem;   // committed remove this cycle
    logic [POS_W-1:0] pos;   // position of the transaction
  } cell_ctrl_t;

endpackage

### sv/ple_cell.sv
// ple_cell: one storage cell of the positional list chain
// holds one entry, shifts from its left or right neighbor on insert/remove
// depends on ple_pkg
module ple_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  ple_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  wr_word,
  input  logic [DATA_WIDTH-1:0]  left_word,
  input  logic [DATA_WIDTH-1:0]  right_word,
  output logic [DATA_WIDTH-1:0]  word_o,
  output logic [DATA_WIDTH-1:0]  rd_o
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;
  logic                  at_pos;
  logic                  above_pos;

  assign at_pos    = (32'(ctrl.pos) == 32'(IDX));
  assign above_pos = (32'(IDX) > 32'(ctrl.pos));

  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins) begin
      if (at_pos) begin
        word_nxt = wr_word;
      end else if (above_pos) begin
        word_nxt = left_word;
      end
    end else if (ctrl.rem) begin
      if (at_pos || above_pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;
  // one-hot contribution to the read bus
  assign rd_o   = at_pos ? word_r : '0;

endmodule

### sv/positional_list_engine.sv
// positional_list_engine: top level of the positional list engine
// instantiates a chain of ple_cell, one per entry
// depends on ple_pkg and ple_cell
//
// An ordered list of up to CAPACITY words with read, insert and remove at a
// position. The request is decoded against the length register, the cells at
// and above the addressed position shift away from it (insert) or toward it
// (remove) at the same clock edge, and the result (status, word, new length)
// is loaded into the output register at the accepting edge. A new
// request is accepted every cycle while the output register is empty or being
// drained, so the sustained rate is one transaction per cycle; the single
// output register is what limits it under back-pressure. Read and remove data
// come from a one-hot OR bus across the cells. Entries have no reset; only
// positions below the length are ever returned.
module positional_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_data_out,
  output logic [4:0]  out_length_out
);

  // length register wide enough to hold CAPACITY itself
  localparam int LEN_W = $clog2(CAPACITY + 1);
  // compare width covers both the length and the position field
  localparam int CMP_W = (LEN_W > ple_pkg::POS_W) ? LEN_W : ple_pkg::POS_W;
  // staging width for moving words between the port and the cells
  localparam int EXT_W = (DATA_WIDTH > ple_pkg::IN_DATA_W) ? DATA_WIDTH
                                                            : ple_pkg::IN_DATA_W;

  logic [LEN_W-1:0]      length_r;
  logic [LEN_W-1:0]      length_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [31:0]           out_data_r;
  logic [4:0]            out_length_r;

  logic                  in_fire;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      len_ext;
  logic                  pos_in_list;   // valid for read/remove
  logic                  pos_in_gap;    // valid for insert, includes append
  logic                  is_full;
  logic                  ins_ok;
  logic                  rem_ok;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] data_sel;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [EXT_W-1:0]      wr_ext;
  logic [EXT_W-1:0]      rd_ext;
  logic [DATA_WIDTH-1:0] rd_word;

  ple_pkg::cell_ctrl_t   ctrl;

  // chain wiring
  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  // handshake: take a transaction whenever the output slot frees up
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // range checks against the current length
  assign pos_ext     = CMP_W'(in_position);
  assign len_ext     = CMP_W'(length_r);
  assign pos_in_list = (pos_ext < len_ext);
  assign pos_in_gap  = (pos_ext <= len_ext);
  assign is_full     = (length_r == LEN_W'(CAPACITY));

  // input word trimmed or zero-extended to the entry width
  assign wr_ext  = EXT_W'(in_value);
  assign wr_word = wr_ext[DATA_WIDTH-1:0];

  // request decode
  always_comb begin
    status   = ple_pkg::ST_OK;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    data_sel = '0;
    case (in_req_type)
      ple_pkg::REQ_READ: begin
        if (pos_in_list) begin
          data_sel = rd_word;
        end else begin
          status = ple_pkg::ST_BAD_POS;
        end
      end
      ple_pkg::REQ_INSERT: begin
        // position checked before fullness
        if (!pos_in_gap) begin
          status = ple_pkg::ST_BAD_POS;
        end else if (is_full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ple_pkg::REQ_REMOVE: begin
        if (pos_in_list) begin
          data_sel = rd_word;
          rem_ok   = 1'b1;
        end else begin
          status = ple_pkg::ST_BAD_POS;
        end
      end
      default: begin
        // unused request code
        status = ple_pkg::ST_BAD_POS;
      end
    endcase
  end

  // broadcast to the chain, only for committed transactions
  assign ctrl.ins = in_fire && ins_ok;
  assign ctrl.rem = in_fire && rem_ok;
  assign ctrl.pos = in_position;

  // cell chain: on insert, cells above the position take from i-1; on remove, cells at and above it take from i+1
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (gi == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[gi+1];
    end
    ple_cell #(
      .IDX        (gi),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_word    (wr_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word_o     (cell_word[gi]),
      .rd_o       (cell_rd[gi])
    );
  end

  // read bus: at most one cell drives a nonzero word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // length update
  always_comb begin
    length_nxt = length_r;
    if (ctrl.ins) begin
      length_nxt = length_r + LEN_W'(1);
    end else if (ctrl.rem) begin
      length_nxt = length_r - LEN_W'(1);
    end
  end

  assign out_valid_nxt = in_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign rd_ext        = EXT_W'(data_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= status;
      out_data_r   <= rd_ext[31:0];
      out_length_r <= ple_pkg::LEN_OUT_W'(length_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_out   = out_data_r;
  assign out_length_out = out_length_r;

`ifndef SYNTHESIS
  // length never exceeds the number of cells
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(length_r) <= 32'(CAPACITY)))
    else $error("length above capacity");

  // a committed insert grows the list by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> (length_r == $past(length_r) + LEN_W'(1)))
    else $error("insert did not grow length");

  // a committed remove shrinks the list by one
  a_rem_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem |=> (length_r == $past(length_r) - LEN_W'(1)))
    else $error("remove did not shrink length");

  // a pending full status matches a full list
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ple_pkg::ST_FULL)) |-> is_full)
    else $error("full status with room left");
`endif

endmodule
